// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the proximity detector.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a condition implies another one on the following edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dirpd_pkg.sv =====
// Package of the differential IR proximity detector: widths, register indexes,
// reset values, output levels and the result record. No dependencies.
`timescale 1ns / 1ps

package dirpd_pkg;

    localparam int DEF_SAMPLES_AVERAGED = 8;

    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 14;
    localparam int TICK_W   = 10;
    localparam int LEVEL_W  = 2;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITAL_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_MIN_SUM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION_SUM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_UP_SUM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_DOWN_SUM = 3'd4;

    // Register reset values
    localparam logic [SUM_W-1:0] RST_FAR_MIN_SUM    = 14'd80;
    localparam logic [SUM_W-1:0] RST_SATURATION_SUM = 14'd6960;
    localparam logic [SUM_W-1:0] RST_RANGE_UP_SUM   = 14'd5600;
    localparam logic [SUM_W-1:0] RST_RANGE_DOWN_SUM = 14'd960;

    // Phase of the tick counter
    localparam logic [1:0] PHASE_DISCARD = 2'd0;
    localparam logic [1:0] PHASE_FAR     = 2'd1;
    localparam logic [1:0] PHASE_AMBIENT = 2'd2;
    localparam logic [1:0] PHASE_NEAR    = 2'd3;

    // Output levels
    localparam logic [LEVEL_W-1:0] LEVEL_OFF         = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_APPROACHING = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_ON          = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL        = 2'd3;

    typedef struct packed {
        logic                near_led_on;
        logic                far_led_on;
        logic [LEVEL_W-1:0]  output_level;
        logic                high_reference;
    } result_t;

endpackage

// ===== hw/rtl/differential_ir_proximity_detector.sv =====
// Differential IR proximity detector: one sample in, one LED/level result out.
// Each result is formed combinationally from the transferred sample and registered;
// throughput 1 sample per cycle while in_ready is high (skid entry empty). A two-entry
// output buffer lets a new sample transfer while a result waits downstream.
// Asynchronous active-low reset clears rings and sums, selects high
// sensitivity and loads the startup hold of 4N+2 ticks.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module differential_ir_proximity_detector #(
    parameter int SAMPLES_AVERAGED = dirpd_pkg::DEF_SAMPLES_AVERAGED
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_en,
    input  logic [dirpd_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [dirpd_pkg::SUM_W-1:0]     cfg_data,
    // sample channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [dirpd_pkg::SAMPLE_W-1:0]  adc_sample,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            near_led_on,
    output logic                            far_led_on,
    output logic [dirpd_pkg::LEVEL_W-1:0]   output_level,
    output logic                            high_reference
);
    import dirpd_pkg::*;

    localparam int POS_W  = $clog2(SAMPLES_AVERAGED);
    localparam int HOLD_W = $clog2(4 * SAMPLES_AVERAGED + 4);
    localparam logic [POS_W-1:0]  POS_LAST    = POS_W'(SAMPLES_AVERAGED - 1);
    localparam logic [HOLD_W-1:0] START_HOLD  = HOLD_W'(4 * SAMPLES_AVERAGED + 2);
    localparam logic [HOLD_W-1:0] SWITCH_HOLD = HOLD_W'(4 * SAMPLES_AVERAGED + 3);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic             digital_mode_reg;
    logic [SUM_W-1:0] far_min_sum_reg;
    logic [SUM_W-1:0] saturation_sum_reg;
    logic [SUM_W-1:0] range_up_sum_reg;
    logic [SUM_W-1:0] range_down_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digital_mode_reg   <= 1'b0;
            far_min_sum_reg    <= RST_FAR_MIN_SUM;
            saturation_sum_reg <= RST_SATURATION_SUM;
            range_up_sum_reg   <= RST_RANGE_UP_SUM;
            range_down_sum_reg <= RST_RANGE_DOWN_SUM;
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                CFG_DIGITAL_MODE:   digital_mode_reg   <= cfg_data[0];
                CFG_FAR_MIN_SUM:    far_min_sum_reg    <= cfg_data;
                CFG_SATURATION_SUM: saturation_sum_reg <= cfg_data;
                CFG_RANGE_UP_SUM:   range_up_sum_reg   <= cfg_data;
                CFG_RANGE_DOWN_SUM: range_down_sum_reg <= cfg_data;
                default:            ; // unused indexes: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Detector state
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]   tick_reg;
    logic [SAMPLE_W-1:0] far_ring_reg     [SAMPLES_AVERAGED];
    logic [SAMPLE_W-1:0] ambient_ring_reg [SAMPLES_AVERAGED];
    logic [SAMPLE_W-1:0] near_ring_reg    [SAMPLES_AVERAGED];
    logic [POS_W-1:0]    far_pos_reg, ambient_pos_reg, near_pos_reg;
    logic [SUM_W-1:0]    far_sum_reg, ambient_sum_reg, near_sum_reg;
    logic                high_sens_reg;
    logic [HOLD_W-1:0]   hold_reg;
    logic                near_led_reg, far_led_reg;
    logic [LEVEL_W-1:0]  level_reg;

    logic                in_xfer;
    logic [1:0]          phase;
    logic [TICK_W-1:0]   tick_next;
    logic [SUM_W-1:0]    far_sum_next, ambient_sum_next, near_sum_next;
    logic                high_sens_next;
    logic [HOLD_W-1:0]   hold_next;
    logic                near_led_next, far_led_next;
    logic [LEVEL_W-1:0]  level_next;
    logic [SUM_W-1:0]    adj_near, adj_far;
    logic                far_above, reading_ok;
    logic [LEVEL_W-1:0]  grade_level;
    result_t             new_result;

    assign in_xfer   = in_valid && in_ready;
    assign phase     = tick_reg[1:0];
    assign tick_next = tick_reg + 1'b1;

    // Moving sums: only the ring of the current phase takes the sample,
    // swapping its oldest reading for the new one.
    always_comb
    begin
        far_sum_next     = far_sum_reg;
        ambient_sum_next = ambient_sum_reg;
        near_sum_next    = near_sum_reg;
        near_led_next    = near_led_reg;
        far_led_next     = far_led_reg;
        case (phase)
            PHASE_DISCARD:
            begin
                far_led_next = 1'b0;
            end
            PHASE_FAR:
            begin
                far_sum_next = far_sum_reg - SUM_W'(far_ring_reg[far_pos_reg])
                               + SUM_W'(adc_sample);
                near_led_next = 1'b1;
            end
            PHASE_AMBIENT:
            begin
                ambient_sum_next = ambient_sum_reg
                                   - SUM_W'(ambient_ring_reg[ambient_pos_reg])
                                   + SUM_W'(adc_sample);
                near_led_next = 1'b0;
            end
            default:
            begin
                near_sum_next = near_sum_reg - SUM_W'(near_ring_reg[near_pos_reg])
                                + SUM_W'(adc_sample);
                far_led_next = 1'b1;
            end
        endcase
    end

    // Proximity grading on ambient-corrected sums, floored at zero.
    always_comb
    begin
        far_above   = far_sum_next > ambient_sum_next;
        adj_far     = far_above ? far_sum_next - ambient_sum_next : '0;
        adj_near    = (near_sum_next > ambient_sum_next) ?
                      near_sum_next - ambient_sum_next : '0;
        reading_ok  = far_above && (adj_far >= far_min_sum_reg);
        if (reading_ok && (adj_near >= adj_far))
            grade_level = digital_mode_reg ? LEVEL_FULL : LEVEL_ON;
        else if (!digital_mode_reg && reading_ok && ({adj_near, 1'b0} >= {1'b0, adj_far}))
            grade_level = LEVEL_APPROACHING;
        else
            grade_level = LEVEL_OFF;
    end

    // Decision: hold, range switch, saturation blink or graded level.
    always_comb
    begin
        hold_next      = hold_reg;
        high_sens_next = high_sens_reg;
        level_next     = level_reg;
        if (hold_reg != '0)
            hold_next = hold_reg - 1'b1;
        else if (high_sens_reg && (near_sum_next >= range_up_sum_reg ||
                                   far_sum_next >= range_up_sum_reg))
        begin
            high_sens_next = 1'b0;
            hold_next      = SWITCH_HOLD;
        end
        else if (!high_sens_reg && near_sum_next < range_down_sum_reg &&
                 far_sum_next < range_down_sum_reg)
        begin
            high_sens_next = 1'b1;
            hold_next      = SWITCH_HOLD;
        end
        else if (far_sum_next >= saturation_sum_reg && near_sum_next > saturation_sum_reg)
            level_next = tick_next[TICK_W-1] ? LEVEL_OFF : LEVEL_FULL;
        else
            level_next = grade_level;
    end

    assign new_result = '{near_led_on:    near_led_next,
                          far_led_on:     far_led_next,
                          output_level:   level_next,
                          high_reference: high_sens_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg        <= '0;
            far_pos_reg     <= '0;
            ambient_pos_reg <= '0;
            near_pos_reg    <= '0;
            far_sum_reg     <= '0;
            ambient_sum_reg <= '0;
            near_sum_reg    <= '0;
            high_sens_reg   <= 1'b1;
            hold_reg        <= START_HOLD;
            near_led_reg    <= 1'b0;
            far_led_reg     <= 1'b0;
            level_reg       <= LEVEL_OFF;
            for (int i = 0; i < SAMPLES_AVERAGED; i++)
            begin
                far_ring_reg[i]     <= '0;
                ambient_ring_reg[i] <= '0;
                near_ring_reg[i]    <= '0;
            end
        end
        else if (in_xfer)
        begin
            tick_reg        <= tick_next;
            far_sum_reg     <= far_sum_next;
            ambient_sum_reg <= ambient_sum_next;
            near_sum_reg    <= near_sum_next;
            high_sens_reg   <= high_sens_next;
            hold_reg        <= hold_next;
            near_led_reg    <= near_led_next;
            far_led_reg     <= far_led_next;
            level_reg       <= level_next;
            case (phase)
                PHASE_FAR:
                begin
                    far_ring_reg[far_pos_reg] <= adc_sample;
                    far_pos_reg <= (far_pos_reg == POS_LAST) ? '0 : far_pos_reg + 1'b1;
                end
                PHASE_AMBIENT:
                begin
                    ambient_ring_reg[ambient_pos_reg] <= adc_sample;
                    ambient_pos_reg <= (ambient_pos_reg == POS_LAST) ?
                                       '0 : ambient_pos_reg + 1'b1;
                end
                PHASE_NEAR:
                begin
                    near_ring_reg[near_pos_reg] <= adc_sample;
                    near_pos_reg <= (near_pos_reg == POS_LAST) ? '0 : near_pos_reg + 1'b1;
                end
                default: ; // discard phase: drop the sample
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output buffer: main result register plus one skid entry, so a new
    // sample can transfer while the current result is stalled.
    // ------------------------------------------------------------------
    result_t out_data_reg, skid_data_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    out_xfer;

    assign in_ready = !skid_valid_reg;
    assign out_xfer = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_xfer || !out_valid_reg)
        begin
            // Advance: the skid entry goes first, else the fresh result.
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= in_xfer;
        end
        else if (in_xfer)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_xfer || !out_valid_reg)
            out_data_reg <= skid_valid_reg ? skid_data_reg : new_result;
        else if (in_xfer)
            skid_data_reg <= new_result;
    end

    assign out_valid      = out_valid_reg;
    assign near_led_on    = out_data_reg.near_led_on;
    assign far_led_on     = out_data_reg.far_led_on;
    assign output_level   = out_data_reg.output_level;
    assign high_reference = out_data_reg.high_reference;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid entry without result")
    `ASSERT_NEXT(a_hold_keeps_level, in_xfer && hold_reg != '0, level_reg == $past(level_reg), "level moved during hold")
    `ASSERT_ALWAYS(a_switch_loads_hold, $stable(high_sens_reg) || hold_reg == SWITCH_HOLD, "range switch without hold reload")

endmodule
